FILE: rtl/ep2c_pkg.sv
// Shared constants and helpers for the epoch-seconds to calendar converter.
// Used by the interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package ep2c_pkg;

	localparam int unsigned SECS_W  = 32;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;

	// Whole days fit in 16 bits for a 32-bit second count
	localparam int unsigned DAYS_W  = 16;

	localparam logic [31:0] DAY_SECS  = 32'd86400;
	localparam logic [31:0] HOUR_SECS = 32'd3600;
	localparam logic [31:0] MIN_SECS  = 32'd60;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	// Residues of the epoch year for the century and 400-year rules
	localparam logic [6:0] EPOCH_MOD100 = 7'd70;
	localparam logic [8:0] EPOCH_MOD400 = 9'd370;

	localparam logic [8:0] COMMON_YEAR_DAYS = 9'd365;
	localparam logic [8:0] LEAP_YEAR_DAYS   = 9'd366;

	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
	localparam logic [MONTH_W-1:0] FEB        = 4'd1;

	// Length of a month, zero-based month index
	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] mon, input logic leap);
		logic [4:0] len;
		begin
			case (mon)
				4'd0:    len = 5'd31;
				4'd1:    len = leap ? 5'd29 : 5'd28;
				4'd2:    len = 5'd31;
				4'd3:    len = 5'd30;
				4'd4:    len = 5'd31;
				4'd5:    len = 5'd30;
				4'd6:    len = 5'd31;
				4'd7:    len = 5'd31;
				4'd8:    len = 5'd30;
				4'd9:    len = 5'd31;
				4'd10:   len = 5'd30;
				default: len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage

FILE: rtl/ep2c_in_if.sv
// Input channel: one epoch second count per transaction.
// Depends on ep2c_pkg for the field width.
`timescale 1ns / 1ps

interface ep2c_in_if;
	logic                          valid;
	logic                          ready;
	logic [ep2c_pkg::SECS_W-1:0]   epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

FILE: rtl/ep2c_out_if.sv
// Output channel: one calendar date and time of day per transaction.
// Depends on ep2c_pkg for the field widths.
`timescale 1ns / 1ps

interface ep2c_out_if;
	logic                          valid;
	logic                          ready;
	logic [ep2c_pkg::YEAR_W-1:0]   year;
	logic [ep2c_pkg::MONTH_W-1:0]  month;
	logic [ep2c_pkg::DAY_W-1:0]    day;
	logic [ep2c_pkg::HOUR_W-1:0]   hour;
	logic [ep2c_pkg::MIN_W-1:0]    minute;
	logic [ep2c_pkg::SEC_W-1:0]    second;

	modport source (output valid, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink   (input valid, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface

FILE: rtl/epoch_seconds_to_calendar.sv
// Top level of the epoch-seconds to Gregorian calendar converter.
// Depends on ep2c_pkg, ep2c_in_if and ep2c_out_if.
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year, month, day, hour, minute and second (valid through 2106-02-07). One
// 33-bit subtract-and-compare unit does all the work under a small sequencer:
// 16 restoring steps split the count into days and leftover seconds, one step
// per year walks the years from 1970 (up to 136 steps plus one to stop), one
// step per month walks the months (up to 12), then 5 and 6 restoring steps
// extract hours and minutes. The year walk dominates the conversion time. The
// block takes one item at a time; req.ready is high only while the sequencer is
// idle. The finished result sits in an output register until taken, and the next
// item may be accepted meanwhile.
module epoch_seconds_to_calendar (
	input  logic              clk,
	input  logic              arst_n,
	ep2c_in_if.sink           req,
	ep2c_out_if.source        rsp
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DAYS    = 3'd1;
	localparam logic [2:0] ST_YEARS   = 3'd2;
	localparam logic [2:0] ST_MONTHS  = 3'd3;
	localparam logic [2:0] ST_HOURS   = 3'd4;
	localparam logic [2:0] ST_MINUTES = 3'd5;
	localparam logic [2:0] ST_FINISH  = 3'd6;

	logic [2:0]                       state_q;
	logic [3:0]                       k_q;
	logic [ep2c_pkg::SECS_W-1:0]      rem_q;
	logic [ep2c_pkg::DAYS_W-1:0]      days_q;
	logic [ep2c_pkg::YEAR_W-1:0]      year_q;
	logic [6:0]                       mod100_q;
	logic [8:0]                       mod400_q;
	logic [ep2c_pkg::MONTH_W-1:0]     mon_q;
	logic [ep2c_pkg::HOUR_W-1:0]      hour_q;
	logic [ep2c_pkg::MIN_W-1:0]       min_q;

	logic                             out_valid_q;
	logic [ep2c_pkg::YEAR_W-1:0]      out_year_q;
	logic [ep2c_pkg::MONTH_W-1:0]     out_month_q;
	logic [ep2c_pkg::DAY_W-1:0]       out_day_q;
	logic [ep2c_pkg::HOUR_W-1:0]      out_hour_q;
	logic [ep2c_pkg::MIN_W-1:0]       out_min_q;
	logic [ep2c_pkg::SEC_W-1:0]       out_sec_q;

	logic                             leap;
	logic [31:0]                      sub_a;
	logic [31:0]                      sub_b;
	logic [32:0]                      sub_full;
	logic                             ge;
	logic                             out_free;

	// Leap rule from the tracked residues
	assign leap = ((year_q[1:0] == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

	// Select operands of the shared subtractor
	always_comb begin
		sub_a = rem_q;
		sub_b = '0;
		unique case (state_q)
			ST_DAYS: begin
				sub_b = ep2c_pkg::DAY_SECS << k_q;
			end
			ST_YEARS: begin
				sub_a = {16'd0, days_q};
				sub_b = {23'd0, leap ? ep2c_pkg::LEAP_YEAR_DAYS : ep2c_pkg::COMMON_YEAR_DAYS};
			end
			ST_MONTHS: begin
				sub_a = {16'd0, days_q};
				sub_b = {27'd0, ep2c_pkg::month_len(mon_q, leap)};
			end
			ST_HOURS: begin
				sub_b = ep2c_pkg::HOUR_SECS << k_q;
			end
			ST_MINUTES: begin
				sub_b = ep2c_pkg::MIN_SECS << k_q;
			end
			default: begin
				sub_b = '0;
			end
		endcase
	end

	// Shared subtract and compare
	assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge       = !sub_full[32];

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_DAYS;
						k_q     <= 4'd15;
					end
				end
				ST_DAYS: begin
					k_q <= k_q - 4'd1;
					if (k_q == 4'd0) begin
						state_q <= ST_YEARS;
					end
				end
				ST_YEARS: begin
					if (!ge) begin
						state_q <= ST_MONTHS;
					end
				end
				ST_MONTHS: begin
					if ((mon_q == ep2c_pkg::LAST_MONTH) || !ge) begin
						state_q <= ST_HOURS;
						k_q     <= 4'd4;
					end
				end
				ST_HOURS: begin
					k_q <= k_q - 4'd1;
					if (k_q == 4'd0) begin
						state_q <= ST_MINUTES;
						k_q     <= 4'd5;
					end
				end
				ST_MINUTES: begin
					k_q <= k_q - 4'd1;
					if (k_q == 4'd0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the conversion
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rem_q    <= req.epoch_seconds;
				days_q   <= '0;
				year_q   <= ep2c_pkg::EPOCH_YEAR;
				mod100_q <= ep2c_pkg::EPOCH_MOD100;
				mod400_q <= ep2c_pkg::EPOCH_MOD400;
				mon_q    <= '0;
			end
			ST_DAYS: begin
				// Restoring step: shift in one quotient bit
				if (ge) begin
					rem_q <= sub_full[31:0];
				end
				days_q <= {days_q[ep2c_pkg::DAYS_W-2:0], ge};
			end
			ST_YEARS: begin
				// Drop one whole year and advance the residues
				if (ge) begin
					days_q   <= sub_full[ep2c_pkg::DAYS_W-1:0];
					year_q   <= year_q + 12'd1;
					mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
					mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
				end
			end
			ST_MONTHS: begin
				if ((mon_q != ep2c_pkg::LAST_MONTH) && ge) begin
					days_q <= sub_full[ep2c_pkg::DAYS_W-1:0];
					mon_q  <= mon_q + 4'd1;
				end
			end
			ST_HOURS: begin
				if (ge) begin
					rem_q <= sub_full[31:0];
				end
				hour_q <= {hour_q[ep2c_pkg::HOUR_W-2:0], ge};
			end
			ST_MINUTES: begin
				if (ge) begin
					rem_q <= sub_full[31:0];
				end
				min_q <= {min_q[ep2c_pkg::MIN_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_year_q  <= year_q;
			out_month_q <= mon_q + 4'd1;
			out_day_q   <= days_q[ep2c_pkg::DAY_W-1:0] + 5'd1;
			out_hour_q  <= hour_q;
			out_min_q   <= min_q;
			out_sec_q   <= rem_q[ep2c_pkg::SEC_W-1:0];
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.year   = out_year_q;
	assign rsp.month  = out_month_q;
	assign rsp.day    = out_day_q;
	assign rsp.hour   = out_hour_q;
	assign rsp.minute = out_min_q;
	assign rsp.second = out_sec_q;

`ifndef SYNTHESIS
	// An accepted transaction starts the day split on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_DAYS))
		else $error("accepted transaction did not start the day split");

	// The year walk never passes the last representable year
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEARS) |-> (year_q <= 12'd2106))
		else $error("year walk ran past 2106");

	// The month walk stays within December
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTHS) |-> (mon_q <= ep2c_pkg::LAST_MONTH))
		else $error("month walk ran past December");

	// A delivered result has month, hour, minute and second in range and a day of at least one
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.month >= 4'd1) && (rsp.month <= 4'd12) && (rsp.day >= 5'd1)
			&& (rsp.hour <= 5'd23) && (rsp.minute <= 6'd59) && (rsp.second <= 6'd59)))
		else $error("result outside calendar range");
`endif

endmodule

FILE: dv/tb.sv
// Self-checking testbench for epoch_seconds_to_calendar: directed table plus random second counts.
// Depends on ep2c_pkg, ep2c_in_if, ep2c_out_if and the converter top level.
`timescale 1ns / 1ps

module tb;

	localparam int DIRECTED_N  = 20;
	localparam int RANDOM_N    = 750;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN       = 200;
	localparam int LIMIT       = 1000000;
	localparam longint unsigned MAX_SECS = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [ep2c_pkg::YEAR_W-1:0]  year;
		logic [ep2c_pkg::MONTH_W-1:0] month;
		logic [ep2c_pkg::DAY_W-1:0]   day;
		logic [ep2c_pkg::HOUR_W-1:0]  hour;
		logic [ep2c_pkg::MIN_W-1:0]   minute;
		logic [ep2c_pkg::SEC_W-1:0]   second;
	} calendar_t;

	typedef struct packed {
		logic [ep2c_pkg::SECS_W-1:0] secs;
		logic                        typed;
		calendar_t                   want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	ep2c_in_if  req_if ();
	ep2c_out_if rsp_if ();

	epoch_seconds_to_calendar dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	calendar_t   pending_dates[$];
	int          errors = 0;
	int          results_seen = 0;
	int          cycles = 0;
	int          phase = 0;

	const int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Hand-checked rows carry their expected date; the rest go through the predictor
	stim_row_t directed [DIRECTED_N] = '{
		'{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd0,  6'd0}},
		'{32'd1,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd0,  6'd1}},
		'{32'd59,         1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd0,  6'd59}},
		'{32'd3599,       1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd59, 6'd59}},
		'{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
		'{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0,  6'd0,  6'd0}},
		'{32'd31535999,   1'b0, '0},
		'{32'd31536000,   1'b0, '0},
		'{32'd68169600,   1'b0, '0},
		'{32'd94608000,   1'b0, '0},
		'{32'd94694399,   1'b0, '0},
		'{32'd94694400,   1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'd978307199,  1'b0, '0},
		'{32'd4107542399, 1'b0, '0},
		'{32'd4291747200, 1'b0, '0},
		'{32'h8000_0000,  1'b0, '0},
		'{32'hAAAA_AAAA,  1'b0, '0},
		'{32'h5555_5555,  1'b0, '0},
		'{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6,  6'd28, 6'd15}}
	};

	function automatic bit is_leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	// Split the count into days and seconds, then walk years and months
	function automatic calendar_t to_calendar(input logic [ep2c_pkg::SECS_W-1:0] secs);
		calendar_t   c;
		int unsigned days;
		int unsigned rest;
		int unsigned yr;
		int unsigned mon;
		int unsigned ylen;
		int unsigned mlen;
		bit          leap;
		days = secs / ep2c_pkg::DAY_SECS;
		rest = secs % ep2c_pkg::DAY_SECS;
		yr = ep2c_pkg::EPOCH_YEAR;
		forever begin
			ylen = is_leap_year(yr) ? ep2c_pkg::LEAP_YEAR_DAYS : ep2c_pkg::COMMON_YEAR_DAYS;
			if (days < ylen)
				break;
			days -= ylen;
			yr++;
		end
		leap = is_leap_year(yr);
		mon = 0;
		while (mon < 11) begin
			mlen = month_days[mon];
			if (mon == 1 && leap)
				mlen = 29;
			if (days < mlen)
				break;
			days -= mlen;
			mon++;
		end
		c.year   = ep2c_pkg::YEAR_W'(yr);
		c.month  = ep2c_pkg::MONTH_W'(mon + 1);
		c.day    = ep2c_pkg::DAY_W'(days + 1);
		c.hour   = ep2c_pkg::HOUR_W'(rest / ep2c_pkg::HOUR_SECS);
		c.minute = ep2c_pkg::MIN_W'((rest % ep2c_pkg::HOUR_SECS) / ep2c_pkg::MIN_SECS);
		c.second = ep2c_pkg::SEC_W'(rest % ep2c_pkg::MIN_SECS);
		return c;
	endfunction

	// Free-running clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Check each output transaction against the oldest pending date
	always @(posedge clk) begin : check_dates
		calendar_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			results_seen++;
			if (pending_dates.size() == 0) begin
				$error("unexpected result %0d-%0d-%0d %0d:%0d:%0d", rsp_if.year, rsp_if.month,
					rsp_if.day, rsp_if.hour, rsp_if.minute, rsp_if.second);
				errors++;
			end else begin
				want = pending_dates.pop_front();
				if (rsp_if.year !== want.year) begin
					$error("year: expected %0d, got %0d", want.year, rsp_if.year);
					errors++;
				end
				if (rsp_if.month !== want.month) begin
					$error("month: expected %0d, got %0d", want.month, rsp_if.month);
					errors++;
				end
				if (rsp_if.day !== want.day) begin
					$error("day: expected %0d, got %0d", want.day, rsp_if.day);
					errors++;
				end
				if (rsp_if.hour !== want.hour) begin
					$error("hour: expected %0d, got %0d", want.hour, rsp_if.hour);
					errors++;
				end
				if (rsp_if.minute !== want.minute) begin
					$error("minute: expected %0d, got %0d", want.minute, rsp_if.minute);
					errors++;
				end
				if (rsp_if.second !== want.second) begin
					$error("second: expected %0d, got %0d", want.second, rsp_if.second);
					errors++;
				end
			end
		end
	end

	// Drive output ready: random stalls per phase, one long hold to back up the block
	initial begin : drive_ready
		int stall_pct;
		int hold_count;
		bit held;
		held = 1'b0;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall_pct = (phase == 0) ? 50 : (phase == 1) ? 6 : 0;
			if (!held && phase == 0 && results_seen >= 40) begin
				held = 1'b1;
				rsp_if.ready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= stall_pct);
				@(posedge clk);
			end
		end
	end

	// Reset, then offer the directed table and the random second counts
	initial begin : drive_requests
		int                          n;
		int                          gap_pct;
		int                          r;
		int unsigned                 y;
		int unsigned                 yy;
		longint unsigned             start_days;
		longint unsigned             s64;
		logic [ep2c_pkg::SECS_W-1:0] secs;
		calendar_t                   want;

		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.epoch_seconds <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (n = 0; n < DIRECTED_N + RANDOM_N; n++) begin
			if (n < DIRECTED_N + RANDOM_N / 3)
				phase = 0;
			else if (n < DIRECTED_N + 2 * RANDOM_N / 3)
				phase = 1;
			else
				phase = 2;
			gap_pct = (phase == 0) ? 6 : (phase == 1) ? 50 : 0;

			// Idle the input between transactions
			while ($urandom_range(99) < gap_pct) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end

			if (n < DIRECTED_N) begin
				secs = directed[n].secs;
				want = directed[n].typed ? directed[n].want : to_calendar(secs);
			end else begin
				r = $urandom_range(99);
				if (r < 40) begin
					s64 = $urandom;
				end else if (r < 65) begin
					// Land on or next to a midnight, or at a random second of that day
					s64 = longint'($urandom_range(49710)) * ep2c_pkg::DAY_SECS;
					case ($urandom_range(3))
						0:       s64 += 0;
						1:       s64 += ep2c_pkg::DAY_SECS - 1;
						2:       s64 += 1;
						default: s64 += $urandom_range(ep2c_pkg::DAY_SECS - 1);
					endcase
				end else if (r < 90) begin
					// Land within a day of a New Year boundary
					y = $urandom_range(2105, 1970);
					start_days = 0;
					for (yy = ep2c_pkg::EPOCH_YEAR; yy <= y; yy++)
						start_days += is_leap_year(yy) ? ep2c_pkg::LEAP_YEAR_DAYS
							: ep2c_pkg::COMMON_YEAR_DAYS;
					s64 = start_days * ep2c_pkg::DAY_SECS;
					if ($urandom_range(1))
						s64 -= $urandom_range(ep2c_pkg::DAY_SECS, 1);
					else
						s64 += $urandom_range(ep2c_pkg::DAY_SECS - 1);
				end else begin
					s64 = MAX_SECS - $urandom_range(200000);
				end
				if (s64 > MAX_SECS)
					s64 = MAX_SECS;
				secs = s64[ep2c_pkg::SECS_W-1:0];
				want = to_calendar(secs);
			end

			req_if.valid <= 1'b1;
			req_if.epoch_seconds <= secs;
			do
				@(posedge clk);
			while (!req_if.ready);
			pending_dates.push_back(want);
		end
		req_if.valid <= 1'b0;

		// Drain outstanding results, then let the sequencer settle
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Converted %0d second counts (%0d directed, %0d random) under three stall mixes",
			results_seen, DIRECTED_N, RANDOM_N);
		$display("including a %0d-cycle output hold that backed up the input.", HOLD_CYCLES);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: epoch_seconds_to_calendar.f
rtl/ep2c_pkg.sv
rtl/ep2c_in_if.sv
rtl/ep2c_out_if.sv
rtl/epoch_seconds_to_calendar.sv
dv/tb.sv
